[sv/rc4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int unsigned TableSize     = 256;
  localparam int unsigned MaxKeyBytesDf = 256;

  typedef enum logic [1:0] {
    REQ_KEY     = 2'd0,
    REQ_DATA    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_GEN_J,
    ST_GEN_SWAP,
    ST_GEN_OUT,
    ST_INIT,
    ST_MIX_RD,
    ST_MIX_ACC,
    ST_MIX_WN,
    ST_MIX_WA
  } state_e;

endpackage

`default_nettype wire

[sv/rc4_stream_cipher_core.sv]
// Data byte with a loaded key: GEN_J, GEN_SWAP, GEN_OUT, then PUSH if the output is held
// (one table read port: S[i], S[j], S[S[i]+S[j]] read in turn; S[i], then S[j] written back).
// Input only in IDLE; non-last key bytes, keyless restarts and keyless data (slot free) stay.
// Key schedule (last key byte or restart): identity fill in INIT, then each mixing step in
// MIX_RD, MIX_ACC, MIX_WN, MIX_WA; no input meanwhile. Reset clears control, indices,
// key length and output valid; the table is rebuilt by the schedule before it is ever read.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_core #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MaxKeyBytesDf
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       key_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            key_missing_o
);

  localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned LenW  = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_KEY_BYTES);

  // memories
  logic [7:0] perm_mem [rc4_pkg::TableSize];
  logic [7:0] key_mem  [MAX_KEY_BYTES];

  logic       perm_we;
  logic [7:0] perm_wa, perm_wd, perm_ra, perm_rd_q;
  logic       key_we;
  logic [KeyAw-1:0] key_wa;
  logic [7:0] key_rd_q;

  rc4_pkg::state_e state_q, state_d;
  logic [7:0] i_q, i_d, j_q, j_d;
  logic [7:0] si_q, si_d, sj_q, sj_d, t_q, t_d;
  logic [7:0] data_q, data_d;
  logic [7:0] n_q, n_d, acc_q, acc_d;
  logic [KeyAw-1:0] kpos_q, kpos_d;
  logic [LenW-1:0] key_len_q, key_len_d, key_fill_q, key_fill_d;
  logic key_ready_q, key_ready_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic out_miss_q, out_miss_d;
  logic [7:0] res_q, res_d;
  logic res_miss_q, res_miss_d;

  logic in_xfer, slot_free, key_fits;
  logic [LenW-1:0] fill_inc, kpos_inc;
  logic [7:0] s_t;

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    perm_rd_q <= perm_mem[perm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= data_byte_i;
    end
    key_rd_q <= key_mem[kpos_q];
  end

  assign in_ready_o    = (state_q == rc4_pkg::ST_IDLE);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign slot_free     = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign key_missing_o = out_miss_q;

  assign key_fits = (key_fill_q < MaxLen);
  assign fill_inc = key_fill_q + LenW'(1);
  assign kpos_inc = LenW'(kpos_q) + LenW'(1);
  assign key_wa   = key_fill_q[KeyAw-1:0];

  // keystream entry after the swap: S[j] now holds old S[i], S[i] holds old S[j]
  always_comb begin
    if (t_q == j_q) begin
      s_t = si_q;
    end else if (t_q == i_q) begin
      s_t = sj_q;
    end else begin
      s_t = perm_rd_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    data_d      = data_q;
    n_d         = n_q;
    acc_d       = acc_q;
    kpos_d      = kpos_q;
    key_len_d   = key_len_q;
    key_fill_d  = key_fill_q;
    key_ready_d = key_ready_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_miss_d  = out_miss_q;
    res_d       = res_q;
    res_miss_d  = res_miss_q;
    perm_we     = 1'b0;
    perm_wa     = 8'd0;
    perm_wd     = 8'd0;
    perm_ra     = i_q + 8'd1;
    key_we      = 1'b0;

    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (rc4_pkg::req_e'(req_type_i))
            rc4_pkg::REQ_KEY: begin
              key_we = key_fits;
              if (key_fits) begin
                key_fill_d = fill_inc;
              end
              if (key_last_i) begin
                key_fill_d = '0;
                if (key_fits || (key_fill_q != '0)) begin
                  key_len_d   = key_fits ? fill_inc : key_fill_q;
                  key_ready_d = 1'b1;
                  n_d         = 8'd0;
                  state_d     = rc4_pkg::ST_INIT;
                end
              end
            end
            rc4_pkg::REQ_DATA: begin
              data_d = data_byte_i;
              if (key_ready_q) begin
                i_d     = i_q + 8'd1;
                state_d = rc4_pkg::ST_GEN_J;
              end else if (slot_free) begin
                out_valid_d = 1'b1;
                out_byte_d  = data_byte_i;
                out_miss_d  = 1'b1;
              end else begin
                res_d      = data_byte_i;
                res_miss_d = 1'b1;
                state_d    = rc4_pkg::ST_PUSH;
              end
            end
            rc4_pkg::REQ_RESTART: begin
              if (key_ready_q) begin
                n_d     = 8'd0;
                state_d = rc4_pkg::ST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      rc4_pkg::ST_PUSH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = res_q;
          out_miss_d  = res_miss_q;
          state_d     = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_GEN_J: begin
        si_d    = perm_rd_q;
        j_d     = j_q + perm_rd_q;
        perm_ra = j_q + perm_rd_q;
        state_d = rc4_pkg::ST_GEN_SWAP;
      end
      rc4_pkg::ST_GEN_SWAP: begin
        sj_d    = perm_rd_q;
        perm_we = 1'b1;
        perm_wa = i_q;
        perm_wd = perm_rd_q;
        perm_ra = si_q + perm_rd_q;
        t_d     = si_q + perm_rd_q;
        state_d = rc4_pkg::ST_GEN_OUT;
      end
      rc4_pkg::ST_GEN_OUT: begin
        perm_we = 1'b1;
        perm_wa = j_q;
        perm_wd = si_q;
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q ^ s_t;
          out_miss_d  = 1'b0;
          state_d     = rc4_pkg::ST_IDLE;
        end else begin
          res_d      = data_q ^ s_t;
          res_miss_d = 1'b0;
          state_d    = rc4_pkg::ST_PUSH;
        end
      end
      rc4_pkg::ST_INIT: begin
        perm_we = 1'b1;
        perm_wa = n_q;
        perm_wd = n_q;
        n_d     = n_q + 8'd1;
        if (n_q == 8'hff) begin
          acc_d   = 8'd0;
          kpos_d  = '0;
          state_d = rc4_pkg::ST_MIX_RD;
        end
      end
      rc4_pkg::ST_MIX_RD: begin
        perm_ra = n_q;
        state_d = rc4_pkg::ST_MIX_ACC;
      end
      rc4_pkg::ST_MIX_ACC: begin
        si_d    = perm_rd_q;
        acc_d   = acc_q + perm_rd_q + key_rd_q;
        perm_ra = acc_q + perm_rd_q + key_rd_q;
        state_d = rc4_pkg::ST_MIX_WN;
      end
      rc4_pkg::ST_MIX_WN: begin
        perm_we = 1'b1;
        perm_wa = n_q;
        perm_wd = perm_rd_q;
        state_d = rc4_pkg::ST_MIX_WA;
      end
      rc4_pkg::ST_MIX_WA: begin
        perm_we = 1'b1;
        perm_wa = acc_q;
        perm_wd = si_q;
        n_d     = n_q + 8'd1;
        kpos_d  = (kpos_inc >= key_len_q) ? '0 : kpos_inc[KeyAw-1:0];
        if (n_q == 8'hff) begin
          i_d     = 8'd0;
          j_d     = 8'd0;
          state_d = rc4_pkg::ST_IDLE;
        end else begin
          state_d = rc4_pkg::ST_MIX_RD;
        end
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      n_q         <= 8'd0;
      acc_q       <= 8'd0;
      kpos_q      <= '0;
      key_len_q   <= '0;
      key_fill_q  <= '0;
      key_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      kpos_q      <= kpos_d;
      key_len_q   <= key_len_d;
      key_fill_q  <= key_fill_d;
      key_ready_q <= key_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
    out_miss_q <= out_miss_d;
    res_q      <= res_d;
    res_miss_q <= res_miss_d;
  end

endmodule

`default_nettype wire

[dv/rc4_stream_cipher_core_tb.sv]
`timescale 1ns / 1ps

module rc4_stream_cipher_core_tb;

  localparam int unsigned KEY_CAP      = rc4_pkg::MaxKeyBytesDf;
  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 8000;
  localparam int unsigned DRAIN_CYCLES = 1400;
  localparam int unsigned REPORT_MAX   = 10;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  typedef struct packed {
    logic [7:0] text;
    logic       no_key;
  } cipher_out_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] req_type_i;
  logic [7:0] data_byte_i;
  logic       key_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       key_missing_o;

  rc4_stream_cipher_core #(
    .MAX_KEY_BYTES(KEY_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .key_last_i   (key_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .key_missing_o(key_missing_o)
  );

  // cipher state as the block should hold it
  logic [7:0]  perm      [rc4_pkg::TableSize];
  logic [7:0]  key_bytes [rc4_pkg::TableSize];
  int unsigned key_len;
  int unsigned key_fill;
  logic [7:0]  gen_i;
  logic [7:0]  gen_j;
  bit          keyed;

  cipher_out_t ciphertext_q[$];
  int unsigned mismatches;
  int unsigned sent_cnt;

  // traffic shaping
  int unsigned gap_max;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void rc4_schedule();
    logic [7:0]  acc;
    logic [7:0]  tmp;
    int unsigned kpos;
    acc  = 8'd0;
    kpos = 0;
    for (int unsigned n = 0; n < rc4_pkg::TableSize; n++) perm[n] = 8'(n);
    for (int unsigned n = 0; n < rc4_pkg::TableSize; n++) begin
      acc       = acc + perm[n] + key_bytes[kpos[7:0]];
      tmp       = perm[n];
      perm[n]   = perm[acc];
      perm[acc] = tmp;
      kpos++;
      if (kpos >= key_len) kpos = 0;
    end
    gen_i = 8'd0;
    gen_j = 8'd0;
  endfunction

  function automatic logic [7:0] rc4_keystream();
    logic [7:0] tmp;
    logic [7:0] idx;
    gen_i       = gen_i + 8'd1;
    gen_j       = gen_j + perm[gen_i];
    tmp         = perm[gen_i];
    perm[gen_i] = perm[gen_j];
    perm[gen_j] = tmp;
    idx         = perm[gen_i] + perm[gen_j];
    return perm[idx];
  endfunction

  // update the expected state for one accepted item
  function automatic void rc4_accept(rc4_pkg::req_e req, logic [7:0] b, logic last);
    cipher_out_t res;
    case (req)
      rc4_pkg::REQ_KEY: begin
        if (key_fill < KEY_CAP && key_fill < rc4_pkg::TableSize) begin
          key_bytes[key_fill] = b;
          key_fill++;
        end
        if (last) begin
          // a dropped byte flagged last still closes the key
          if (key_fill > 0) begin
            key_len = key_fill;
            keyed   = 1'b1;
            rc4_schedule();
          end
          key_fill = 0;
        end
      end
      rc4_pkg::REQ_DATA: begin
        if (keyed) begin
          res.text   = b ^ rc4_keystream();
          res.no_key = 1'b0;
        end else begin
          res.text   = b;
          res.no_key = 1'b1;
        end
        ciphertext_q.push_back(res);
      end
      rc4_pkg::REQ_RESTART: begin
        if (keyed) rc4_schedule();
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, string want, string got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s mismatch, expected %s, got %s", $realtime, what, want, got);
    end
  endfunction

  // called at a falling edge, returns at a falling edge with valid low
  task automatic send_item(rc4_pkg::req_e req, logic [7:0] b, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i  = 1'b1;
    req_type_i  = req;
    data_byte_i = b;
    key_last_i  = last;
    do @(posedge clk_i); while (!in_ready_o);
    rc4_accept(req, b, last);
    if (req != rc4_pkg::REQ_NONE) sent_cnt++;
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic load_key(int unsigned len);
    for (int unsigned k = 1; k <= len; k++) begin
      send_item(rc4_pkg::REQ_KEY, 8'($urandom), k == len);
    end
  endtask

  task automatic send_data(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_item(rc4_pkg::REQ_DATA, 8'($urandom), 1'($urandom));
    end
  endtask

  // data and restart before any key, plus the unused request code
  task automatic test_no_key();
    send_item(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_RESTART, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_NONE, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h5A, 1'b0);
  endtask

  // one-byte keys at both extremes, restart with a loaded key
  task automatic test_short_keys();
    send_item(rc4_pkg::REQ_KEY, 8'h00, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::REQ_RESTART, 8'h00, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h00, 1'b1);
    send_item(rc4_pkg::REQ_KEY, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h80, 1'b0);
  endtask

  // restart while a new key is half written uses the old length
  task automatic test_key_rewrite();
    send_item(rc4_pkg::REQ_KEY, 8'h12, 1'b0);
    send_item(rc4_pkg::REQ_KEY, 8'h34, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'hA5, 1'b0);
    send_item(rc4_pkg::REQ_KEY, 8'hAB, 1'b0);
    send_item(rc4_pkg::REQ_RESTART, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::REQ_KEY, 8'hCD, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h3C, 1'b0);
  endtask

  // full-size key, then an oversized key closed by a dropped byte
  task automatic test_long_keys();
    load_key(KEY_CAP);
    send_data(6);
    load_key(KEY_CAP + 4);
    send_data(6);
    send_item(rc4_pkg::REQ_RESTART, 8'($urandom), 1'b0);
    send_data(4);
  endtask

  // output held off long enough that the input backs up
  task automatic test_output_stall();
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    load_key(5);
    // first byte waits out the schedule, so the hold covers the data that follows
    send_data(1);
    hold_req = 1'b1;
    send_data(20);
    while (hold_req) @(negedge clk_i);
  endtask

  task automatic test_random_traffic();
    int unsigned klen;
    int unsigned split;
    int unsigned ndata;
    while (sent_cnt < ITEM_TARGET) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 19))
        0, 1, 2: klen = $urandom_range(17, KEY_CAP);
        3:       klen = $urandom_range(KEY_CAP + 1, KEY_CAP + 44);
        default: klen = $urandom_range(1, 16);
      endcase
      split = (klen > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(1, klen - 1) : 0;
      if (split > 0) begin
        for (int unsigned k = 0; k < split; k++) begin
          send_item(rc4_pkg::REQ_KEY, 8'($urandom), 1'b0);
        end
        send_item(rc4_pkg::REQ_RESTART, 8'($urandom), 1'($urandom));
        send_data($urandom_range(1, 6));
        for (int unsigned k = split + 1; k <= klen; k++) begin
          send_item(rc4_pkg::REQ_KEY, 8'($urandom), k == klen);
        end
      end else begin
        load_key(klen);
      end
      ndata = $urandom_range(4, 60);
      for (int unsigned d = 0; d < ndata; d++) begin
        case ($urandom_range(0, 39))
          0:       send_item(rc4_pkg::REQ_RESTART, 8'($urandom), 1'($urandom));
          1:       send_item(rc4_pkg::REQ_NONE, 8'($urandom), 1'($urandom));
          default: send_item(rc4_pkg::REQ_DATA, 8'($urandom), 1'($urandom));
        endcase
      end
    end
  endtask

  // receiver side
  initial begin : rx_drive
    logic [7:0] pat;
    pat         = 8'b1011_0110;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready_i = 1'b1;
          RX_RANDOM: out_ready_i = 1'($urandom);
          RX_SPARSE: out_ready_i = ($urandom_range(0, 7) != 0);
          default: begin
            out_ready_i = pat[0];
            pat         = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  initial begin : result_check
    cipher_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (ciphertext_q.size() == 0) begin
          note_mismatch("result transfer", "none pending",
                        $sformatf("%02h/%0b", out_byte_o, key_missing_o));
        end else begin
          want = ciphertext_q.pop_front();
          if (out_byte_o !== want.text) begin
            note_mismatch("out_byte", $sformatf("%02h", want.text),
                          $sformatf("%02h", out_byte_o));
          end
          if (key_missing_o !== want.no_key) begin
            note_mismatch("key_missing", $sformatf("%0b", want.no_key),
                          $sformatf("%0b", key_missing_o));
          end
        end
      end
    end
  end

  // ends the run if no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = rc4_pkg::REQ_KEY;
    data_byte_i = 8'h00;
    key_last_i  = 1'b0;
    mismatches  = 0;
    sent_cnt    = 0;
    gap_max     = 0;
    burst_left  = 0;
    rx_mode     = RX_ALWAYS;
    hold_req    = 1'b0;
    key_len     = 0;
    key_fill    = 0;
    gen_i       = 8'd0;
    gen_j       = 8'd0;
    keyed       = 1'b0;
    for (int unsigned n = 0; n < rc4_pkg::TableSize; n++) begin
      perm[n]      = 8'd0;
      key_bytes[n] = 8'd0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_no_key();
    test_short_keys();
    test_key_rewrite();
    gap_max = 6;
    rx_mode = RX_RANDOM;
    test_long_keys();
    test_output_stall();
    test_random_traffic();

    rx_mode = RX_ALWAYS;
    while (ciphertext_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
